// ===== design/dccser_pkg.sv =====
package dccser_pkg;

  // Packet store geometry
  localparam int MAX_BYTES   = 6;
  localparam int QUEUE_DEPTH = 8;
  // One slot more than the queue holds: the packet on the line keeps its slot
  localparam int SLOTS       = QUEUE_DEPTH + 1;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = $clog2(MAX_BYTES + 1);
  localparam int BPOS_W      = $clog2(MAX_BYTES);
  localparam int MEM_DEPTH   = SLOTS * MAX_BYTES;
  localparam int MADDR_W     = $clog2(MEM_DEPTH);
  localparam int IDLE_LEN    = 3;

  // Item queue between front and back
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = 1;
  localparam int OPQ_CNT_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HALF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HALF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_1ST  = 2'd3;

  // Write status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  // Serializer phases
  localparam logic [2:0] PH_BETWEEN  = 3'd0;
  localparam logic [2:0] PH_PREAMBLE = 3'd1;
  localparam logic [2:0] PH_START    = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_SEP      = 3'd4;
  localparam logic [2:0] PH_EXTRA    = 3'd5;
  localparam logic [2:0] PH_END      = 3'd6;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       byte_last;
    logic [3:0] repeat_count;
    logic       foreign_proto;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  write_status;
    logic        first_level;
    logic [14:0] first_ticks;
    logic        second_level;
    logic [14:0] second_ticks;
    logic        end_of_packet;
  } out_item_t;

  // Decoded item handed from front to back
  typedef struct packed {
    logic       is_symbol;
    logic [7:0] data_byte;
    logic       byte_last;
    logic [3:0] repeat_count;
    logic       refused_proto;
  } op_t;

  typedef struct packed {
    logic [5:0]  preamble_bits;
    logic [14:0] one_half_ticks;
    logic [14:0] zero_half_ticks;
    logic        high_first;
  } cfg_t;

  // Bytes of the idle packet FF 00 FF
  function automatic logic [7:0] idle_byte(input logic [BPOS_W-1:0] pos);
    idle_byte = (pos == BPOS_W'(1)) ? 8'h00 : 8'hFF;
  endfunction

endpackage

// ===== design/dccser_front.sv =====
module dccser_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dccser_pkg::in_item_t in_data,
  output logic                op_valid,
  output dccser_pkg::op_t     op,
  input  logic                op_take
);
  import dccser_pkg::*;

  op_t                  q_r [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_r, rd_r;
  logic [OPQ_CNT_W-1:0] cnt_r;
  logic                 push;
  op_t                  dec;

  assign in_stall = (cnt_r == OPQ_CNT_W'(OPQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rd_r];

  always_comb begin
    dec.is_symbol     = in_data.mode;
    dec.data_byte     = in_data.data_byte;
    dec.byte_last     = in_data.byte_last;
    dec.repeat_count  = in_data.repeat_count;
    dec.refused_proto = in_data.foreign_proto;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (op_take) begin
        rd_r <= (rd_r == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !op_take) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && op_take) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= dec;
    end
  end

endmodule

// ===== design/dccser_back.sv =====
module dccser_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dccser_pkg::cfg_t     cfg,
  input  logic                 op_valid,
  input  dccser_pkg::op_t      op,
  output logic                 op_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dccser_pkg::out_item_t out_data
);
  import dccser_pkg::*;

  // Packet store
  logic [7:0]        mem [MEM_DEPTH];
  logic [FILL_W-1:0] len_r [SLOTS];
  logic [3:0]        rpt_r [SLOTS];
  logic [7:0]        rdata_r;

  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // Packet on the line
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic              cur_idle_r, cur_idle_nxt;
  logic [FILL_W-1:0] cur_len_r, cur_len_nxt;
  logic [3:0]        rep_r, rep_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [5:0]        pcnt_r, pcnt_nxt;
  logic [BPOS_W-1:0] bpos_r, bpos_nxt;
  logic [3:0]        bit_r, bit_nxt;

  logic              out_valid_r;
  out_item_t         out_r, res;

  logic              mem_we, len_we;
  logic [MADDR_W-1:0] mem_waddr, mem_raddr;
  logic [2:0]        ph;
  logic [5:0]        pc;
  logic [1:0]        status;
  logic              sym_bit;
  logic [14:0]       ticks;
  logic [7:0]        cur_byte;

  assign op_take   = op_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur_byte  = cur_idle_r ? idle_byte(bpos_r) : rdata_r;
  assign mem_waddr = MADDR_W'(tail_r) * MADDR_W'(MAX_BYTES) + MADDR_W'(fill_r);
  // Keeps rdata_r tracking the byte under the current position
  assign mem_raddr = MADDR_W'(cur_slot_nxt) * MADDR_W'(MAX_BYTES) + MADDR_W'(bpos_nxt);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    fill_nxt     = fill_r;
    cur_slot_nxt = cur_slot_r;
    cur_idle_nxt = cur_idle_r;
    cur_len_nxt  = cur_len_r;
    rep_nxt      = rep_r;
    phase_nxt    = phase_r;
    pcnt_nxt     = pcnt_r;
    bpos_nxt     = bpos_r;
    bit_nxt      = bit_r;
    mem_we       = 1'b0;
    len_we       = 1'b0;
    status       = ST_OK;
    ph           = phase_r;
    pc           = pcnt_r;
    sym_bit      = 1'b0;
    ticks        = '0;
    res          = '0;

    if (op_take && !op.is_symbol) begin
      if (op.refused_proto) begin
        status = ST_UNSUP;
      end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
        status = ST_FULL;
      end else if (fill_r >= FILL_W'(MAX_BYTES)) begin
        status = ST_LONG;
      end
      if (status != ST_OK) begin
        fill_nxt = '0;
      end else begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (op.byte_last) begin
          len_we    = 1'b1;
          tail_nxt  = (tail_r == SLOT_W'(SLOTS - 1)) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
          fill_nxt  = '0;
        end
      end
      res.write_status = status;
    end else if (op_take) begin
      res.result_kind = 1'b1;
      if (phase_r == PH_BETWEEN) begin
        if (rep_r != '0) begin
          rep_nxt = rep_r - 1'b1;
        end else if (count_r != '0) begin
          cur_slot_nxt = head_r;
          cur_idle_nxt = 1'b0;
          cur_len_nxt  = len_r[head_r];
          rep_nxt      = rpt_r[head_r];
          head_nxt     = (head_r == SLOT_W'(SLOTS - 1)) ? '0 : head_r + 1'b1;
          count_nxt    = count_r - 1'b1;
        end else begin
          cur_idle_nxt = 1'b1;
          cur_len_nxt  = FILL_W'(IDLE_LEN);
          rep_nxt      = '0;
        end
        ph = PH_PREAMBLE;
        pc = '0;
      end
      if (ph == PH_PREAMBLE && pc >= cfg.preamble_bits) begin
        ph = PH_START;
      end
      phase_nxt = ph;
      pcnt_nxt  = pc;
      case (ph)
        PH_PREAMBLE: begin
          sym_bit  = 1'b1;
          pcnt_nxt = pc + 1'b1;
        end
        PH_START: begin
          sym_bit   = 1'b0;
          phase_nxt = PH_DATA;
          bpos_nxt  = '0;
          bit_nxt   = '0;
        end
        PH_DATA: begin
          sym_bit = cur_byte[3'd7 - bit_r[2:0]];
          bit_nxt = bit_r + 1'b1;
          if (bit_r == 4'd7) begin
            phase_nxt = PH_SEP;
          end
        end
        PH_SEP: begin
          sym_bit = (FILL_W'(bpos_r) + 1'b1 >= cur_len_r);
          if (sym_bit) begin
            phase_nxt = PH_EXTRA;
          end else begin
            bpos_nxt  = bpos_r + 1'b1;
            bit_nxt   = '0;
            phase_nxt = PH_DATA;
          end
        end
        PH_EXTRA: begin
          sym_bit   = 1'b1;
          phase_nxt = PH_END;
        end
        default: begin
          phase_nxt = PH_BETWEEN;
        end
      endcase
      ticks = sym_bit ? cfg.one_half_ticks : cfg.zero_half_ticks;
      if (ph == PH_END || ph == PH_BETWEEN) begin
        res.end_of_packet = 1'b1;
      end else begin
        res.first_level  = cfg.high_first;
        res.first_ticks  = ticks;
        res.second_level = !cfg.high_first;
        res.second_ticks = ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      cur_idle_r  <= 1'b0;
      cur_len_r   <= '0;
      rep_r       <= '0;
      phase_r     <= PH_BETWEEN;
      pcnt_r      <= '0;
      bpos_r      <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      fill_r     <= fill_nxt;
      cur_idle_r <= cur_idle_nxt;
      cur_len_r  <= cur_len_nxt;
      rep_r      <= rep_nxt;
      phase_r    <= phase_nxt;
      pcnt_r     <= pcnt_nxt;
      bpos_r     <= bpos_nxt;
      bit_r      <= bit_nxt;
      if (op_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_slot_r <= cur_slot_nxt;
    if (op_take) begin
      out_r <= res;
    end
    if (len_we) begin
      len_r[tail_r] <= fill_r + 1'b1;
      rpt_r[tail_r] <= op.repeat_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= op.data_byte;
    end
    rdata_r <= mem[mem_raddr];
  end

endmodule

// ===== design/dcc_track_packet_serializer_top.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_item_t (write byte or symbol request)
// out_      output     out_valid/out_stall  out_item_t (write status or symbol)
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall stays low; with nothing waiting
// ahead of it, an accepted item goes through the item queue, then the execute
// stage, into the output register.
// The packet store is one write / one read port memory; the byte under the
// current position is read ahead, so data symbols never wait for it.
// rst_n is synchronous; the packet store itself is not cleared.
// in_stall rises only when the two-entry item queue is full.
module dcc_track_packet_serializer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dccser_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dccser_pkg::out_item_t                out_data,
  input  logic                                 cfg_we,
  input  logic [dccser_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dccser_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dccser_pkg::*;

  cfg_t cfg_r;
  logic op_valid, op_take;
  op_t  op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_bits   <= 6'd16;
      cfg_r.one_half_ticks  <= 15'd58;
      cfg_r.zero_half_ticks <= 15'd100;
      cfg_r.high_first      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREAMBLE:  cfg_r.preamble_bits   <= cfg_wdata[5:0];
        CFG_ONE_HALF:  cfg_r.one_half_ticks  <= cfg_wdata[14:0];
        CFG_ZERO_HALF: cfg_r.zero_half_ticks <= cfg_wdata[14:0];
        CFG_HIGH_1ST:  cfg_r.high_first      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dccser_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  dccser_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== verif/dcc_track_packet_serializer_top_tb.sv =====
`timescale 1ns / 1ps

module dcc_track_packet_serializer_top_tb;
  import dccser_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 320;
  localparam int HOLD_CYCLES = 100;
  localparam in_item_t SYM_REQ = '{mode: 1'b1, default: '0};

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors = 0;
  int cycles = 0;
  int snd_idle = 18;
  int rcv_idle = 68;
  out_item_t expected_results[$];

  // Line encoder state as the block should hold it
  logic [5:0]  c_pre = 6'd16;
  logic [14:0] c_one = 15'd58;
  logic [14:0] c_zero = 15'd100;
  logic        c_hf = 1'b1;
  logic [7:0]  q_bytes [QUEUE_DEPTH*MAX_BYTES] = '{default: '0};
  int          q_len [QUEUE_DEPTH] = '{default: 0};
  logic [3:0]  q_rep [QUEUE_DEPTH] = '{default: '0};
  int          q_head = 0;
  int          q_tail = 0;
  int          q_cnt = 0;
  int          fill_idx = 0;
  logic [7:0]  cur_bytes [MAX_BYTES] = '{default: '0};
  int          cur_len = 0;
  int          reps_left = 0;
  logic [2:0]  ser_phase = PH_BETWEEN;
  int          pre_cnt = 0;
  int          byte_pos = 0;
  int          bit_pos = 0;

  dcc_track_packet_serializer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t line_symbol(input logic one);
    out_item_t r;
    r = '0;
    r.result_kind  = 1'b1;
    r.first_level  = c_hf;
    r.first_ticks  = one ? c_one : c_zero;
    r.second_level = ~c_hf;
    r.second_ticks = one ? c_one : c_zero;
    return r;
  endfunction

  function automatic out_item_t status_item(input logic [1:0] st);
    out_item_t r;
    r = '0;
    r.write_status = st;
    return r;
  endfunction

  function automatic in_item_t wr(input logic [7:0] d, input logic last,
                                  input logic [3:0] rep, input logic mk);
    in_item_t it;
    it.mode          = 1'b0;
    it.data_byte     = d;
    it.byte_last     = last;
    it.repeat_count  = rep;
    it.foreign_proto = mk;
    return it;
  endfunction

  // Advances the encoder state by one item and returns the line result
  function automatic out_item_t serialize_step(input in_item_t it);
    out_item_t  r;
    logic [1:0] st;
    logic       last;
    int         k;
    r = '0;
    if (!it.mode) begin
      st = ST_OK;
      if (it.foreign_proto) st = ST_UNSUP;
      else if (q_cnt >= QUEUE_DEPTH) st = ST_FULL;
      else if (fill_idx >= MAX_BYTES) st = ST_LONG;
      if (st != ST_OK) begin
        fill_idx = 0;
      end else begin
        q_bytes[q_tail*MAX_BYTES + fill_idx] = it.data_byte;
        fill_idx++;
        if (it.byte_last) begin
          q_len[q_tail] = fill_idx;
          q_rep[q_tail] = it.repeat_count;
          q_tail = (q_tail + 1) % QUEUE_DEPTH;
          q_cnt++;
          fill_idx = 0;
        end
      end
      r.write_status = st;
      return r;
    end

    if (ser_phase == PH_BETWEEN) begin
      if (reps_left > 0) begin
        reps_left--;
      end else if (q_cnt > 0) begin
        for (k = 0; k < q_len[q_head]; k++) cur_bytes[k] = q_bytes[q_head*MAX_BYTES + k];
        cur_len   = q_len[q_head];
        reps_left = q_rep[q_head];
        q_head    = (q_head + 1) % QUEUE_DEPTH;
        q_cnt--;
      end else begin
        // empty queue: idle packet
        cur_bytes[0] = 8'hFF;
        cur_bytes[1] = 8'h00;
        cur_bytes[2] = 8'hFF;
        cur_len      = 3;
        reps_left    = 0;
      end
      ser_phase = PH_PREAMBLE;
      pre_cnt   = 0;
    end
    if (ser_phase == PH_PREAMBLE && pre_cnt >= c_pre) ser_phase = PH_START;

    case (ser_phase)
      PH_PREAMBLE: begin
        r = line_symbol(1'b1);
        pre_cnt++;
      end
      PH_START: begin
        r = line_symbol(1'b0);
        ser_phase = PH_DATA;
        byte_pos  = 0;
        bit_pos   = 0;
      end
      PH_DATA: begin
        r = line_symbol(cur_bytes[byte_pos][7-bit_pos]);
        bit_pos++;
        if (bit_pos >= 8) ser_phase = PH_SEP;
      end
      PH_SEP: begin
        last = (byte_pos + 1 >= cur_len);
        r = line_symbol(last);
        if (last) begin
          ser_phase = PH_EXTRA;
        end else begin
          byte_pos++;
          bit_pos   = 0;
          ser_phase = PH_DATA;
        end
      end
      PH_EXTRA: begin
        r = line_symbol(1'b1);
        ser_phase = PH_END;
      end
      default: begin
        r.result_kind   = 1'b1;
        r.end_of_packet = 1'b1;
        ser_phase = PH_BETWEEN;
      end
    endcase
    return r;
  endfunction

  task automatic flag(input string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  task automatic offer(input in_item_t it, input bit known = 1'b0,
                       input out_item_t typed = '0);
    out_item_t pred;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = serialize_step(it);
    expected_results.push_back(known ? typed : pred);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_regs(input logic [14:0] pre_w, input logic [14:0] one_w,
                           input logic [14:0] zero_w, input logic [14:0] hf_w);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PREAMBLE;
    cfg_wdata <= pre_w;
    @(posedge clk);
    cfg_index <= CFG_ONE_HALF;
    cfg_wdata <= one_w;
    @(posedge clk);
    cfg_index <= CFG_ZERO_HALF;
    cfg_wdata <= zero_w;
    @(posedge clk);
    cfg_index <= CFG_HIGH_1ST;
    cfg_wdata <= hf_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    c_pre  = pre_w[5:0];
    c_one  = one_w;
    c_zero = zero_w;
    c_hf   = hf_w[0];
  endtask

  // Result side: checking, random stall, and two long hold-offs
  initial begin : result_check
    out_item_t want;
    int        seen;
    int        hold_left;
    int        hold_mark;
    seen      = 0;
    hold_left = 0;
    hold_mark = 300;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen++;
        if (expected_results.size() == 0) begin
          flag($sformatf("result %0d arrived with none expected: %p", seen, out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.write_status !== want.write_status ||
              out_data.first_level !== want.first_level ||
              out_data.first_ticks !== want.first_ticks ||
              out_data.second_level !== want.second_level ||
              out_data.second_ticks !== want.second_ticks ||
              out_data.end_of_packet !== want.end_of_packet)
            flag($sformatf("result %0d: expected %p, got %p", seen, want, out_data));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (seen == hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_mark += 1200;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("dcc_track_packet_serializer_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    logic [14:0] reg_plan [6][4];
    int          burst_cap [6];
    in_item_t    it;
    logic [31:0] rnd;
    logic [3:0]  rep;
    out_item_t   first_one;
    int          p;
    int          n;
    int          b;
    int          len;
    int          mk_at;
    bit          paused;

    reg_plan = '{'{15'd2,     15'd1,     15'd32767, 15'd0},
                 '{15'd0,     15'd0,     15'd0,     15'h7FFF},
                 '{15'h7FFF,  15'd32767, 15'd1,     15'd2},
                 '{15'd11,    15'd58,    15'd100,   15'd1},
                 '{15'd32,    15'd12345, 15'd6789,  15'd0},
                 '{15'd0,     15'd0,     15'd0,     15'd0}};
    burst_cap = '{20, 60, 80, 40, 8, 40};
    rnd = $urandom;
    reg_plan[5][0] = {12'd0, rnd[2:0]};
    reg_plan[5][3] = {14'd0, rnd[3]};
    rnd = $urandom;
    reg_plan[5][1] = rnd[14:0];
    reg_plan[5][2] = rnd[29:15];

    first_one = '0;
    first_one.result_kind  = 1'b1;
    first_one.first_level  = 1'b1;
    first_one.first_ticks  = 15'd58;
    first_one.second_ticks = 15'd58;

    // first symbol after reset, refused protocol, too long, queue full
    plan.push_back('{SYM_REQ, 1'b1, first_one});
    plan.push_back('{wr(8'hA5, 1'b1, 4'd0, 1'b1), 1'b1, status_item(ST_UNSUP)});
    plan.push_back('{wr(8'h00, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'hFF, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h55, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'hAA, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h01, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h80, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h7E, 1'b1, 4'd0, 1'b0), 1'b1, status_item(ST_LONG)});
    plan.push_back('{wr(8'hC3, 1'b1, 4'd15, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h00, 1'b1, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'hFF, 1'b1, 4'd1, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h3C, 1'b1, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h81, 1'b1, 4'd2, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h5A, 1'b1, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'hF0, 1'b1, 4'd8, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h0F, 1'b1, 4'd0, 1'b0), 1'b1, status_item(ST_OK)});
    plan.push_back('{wr(8'h11, 1'b1, 4'd0, 1'b0), 1'b1, status_item(ST_FULL)});
    plan.push_back('{wr(8'h22, 1'b1, 4'd0, 1'b1), 1'b1, status_item(ST_UNSUP)});
    plan.push_back('{wr(8'h33, 1'b0, 4'd0, 1'b0), 1'b1, status_item(ST_FULL)});
    repeat (5) plan.push_back('{SYM_REQ, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer(plan[i].stim, plan[i].known, plan[i].want);

    for (p = 0; p < 6; p++) begin
      wait_all_results();
      load_regs(reg_plan[p][0], reg_plan[p][1], reg_plan[p][2], reg_plan[p][3]);
      snd_idle = (p < 2) ? 18 : (p < 4) ? 68 : 0;
      rcv_idle = (p < 2) ? 68 : (p < 4) ? 18 : 0;
      n = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        if (!paused && n >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_all_results();
        end
        b = $urandom_range(0, 99);
        if (b < 40) begin
          // one packet, now and then too long or refused part way
          len = $urandom_range(1, MAX_BYTES);
          if ($urandom_range(0, 19) == 0) len = MAX_BYTES + 1;
          mk_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
          rnd = $urandom;
          rep = (rnd[31:30] == 2'b00) ? rnd[3:0] : {3'b000, rnd[4]};
          for (b = 0; b < len; b++) begin
            rnd = $urandom;
            offer(wr(rnd[7:0], b == len - 1, rep, b == mk_at));
            n++;
          end
        end else if (b < 46) begin
          rnd = $urandom;
          it = rnd[$bits(in_item_t)-1:0];
          offer(it);
          n++;
        end else begin
          repeat ($urandom_range(1, burst_cap[p])) begin
            rnd = $urandom;
            it = rnd[$bits(in_item_t)-1:0];
            it.mode = 1'b1;
            offer(it);
            n++;
          end
        end
      end
      // leave the line mid-preamble so the next, shorter preamble cuts it short
      if (p == 2) begin
        while (!(ser_phase == PH_PREAMBLE && pre_cnt > reg_plan[3][0])) offer(SYM_REQ);
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("dcc_track_packet_serializer_top_tb: clean");
    end else begin
      $display("dcc_track_packet_serializer_top_tb: errors");
    end
    $finish;
  end

endmodule
